// ----- rtl/scd_pkg.sv -----
`timescale 1ns / 1ps
// scd_pkg: shared types, key constants and character tables of the scan code decoder
// no dependencies

package scd_pkg;

  // size of the held-key set
  localparam int HELD_KEYS = 8;
  localparam int IDX_W     = (HELD_KEYS > 1) ? $clog2(HELD_KEYS) : 1;
  localparam int COUNT_W   = $clog2(HELD_KEYS + 1);

  // field widths
  localparam int BYTE_W = 8;
  localparam int CODE_W = 7;
  localparam int MOD_W  = 5;
  localparam int LOCK_W = 3;
  localparam int HELD_W = 4;

  // prefix bytes
  localparam logic [BYTE_W-1:0] PFX_NONE = 8'h00;
  localparam logic [BYTE_W-1:0] PFX_E0   = 8'hE0;
  localparam logic [BYTE_W-1:0] PFX_E1   = 8'hE1;

  // key codes of interest
  localparam logic [CODE_W-1:0] KEY_NONE     = 7'd0;
  localparam logic [CODE_W-1:0] KEY_DIV      = 7'd8;
  localparam logic [CODE_W-1:0] KEY_CTRL     = 7'd29;
  localparam logic [CODE_W-1:0] KEY_LSHIFT   = 7'd42;
  localparam logic [CODE_W-1:0] KEY_SLASH    = 7'd53;
  localparam logic [CODE_W-1:0] KEY_RSHIFT   = 7'd54;
  localparam logic [CODE_W-1:0] KEY_ALT      = 7'd56;
  localparam logic [CODE_W-1:0] KEY_CAPS     = 7'd58;
  localparam logic [CODE_W-1:0] KEY_NUM      = 7'd69;
  localparam logic [CODE_W-1:0] KEY_SCROLL   = 7'd70;
  localparam logic [CODE_W-1:0] KEY_PAD_LO   = 7'd71;
  localparam logic [CODE_W-1:0] KEY_DEL      = 7'd83;

  // modifier bit positions
  localparam int M_SHIFT  = 0;
  localparam int M_CTRL_L = 1;
  localparam int M_CTRL_R = 2;
  localparam int M_ALT_L  = 3;
  localparam int M_ALT_R  = 4;

  // lock bit positions (LED byte order)
  localparam int L_SCROLL = 0;
  localparam int L_NUM    = 1;
  localparam int L_CAPS   = 2;

  // held-set sequencer request and response
  typedef struct packed {
    logic              start;
    logic              brk;
    logic [CODE_W-1:0] code;
  } held_req_t;

  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } held_rsp_t;

  // decoder inputs: byte and current state
  typedef struct packed {
    logic [BYTE_W-1:0] scan_byte;
    logic [BYTE_W-1:0] prefix;
    logic [MOD_W-1:0]  mods;
    logic [LOCK_W-1:0] locks;
  } dec_in_t;

  // decoder outputs: next state and result
  typedef struct packed {
    logic [BYTE_W-1:0] prefix_next;
    logic [MOD_W-1:0]  mods_next;
    logic [LOCK_W-1:0] locks_next;
    logic              key_valid;
    logic [BYTE_W-1:0] ascii_char;
    logic [CODE_W-1:0] key_code;
    logic              led_update;
    logic              reboot_request;
  } dec_out_t;

  // unshifted German layout
  function automatic logic [BYTE_W-1:0] plain_char(input logic [CODE_W-1:0] c);
    logic [BYTE_W-1:0] ch;
    ch = 8'd0;
    case (c)
      7'd2:  ch = "1";
      7'd3:  ch = "2";
      7'd4:  ch = "3";
      7'd5:  ch = "4";
      7'd6:  ch = "5";
      7'd7:  ch = "6";
      7'd8:  ch = "7";
      7'd9:  ch = "8";
      7'd10: ch = "9";
      7'd11: ch = "0";
      7'd12: ch = 8'd225;
      7'd13: ch = 8'd39;
      7'd14: ch = 8'd8;
      7'd16: ch = "q";
      7'd17: ch = "w";
      7'd18: ch = "e";
      7'd19: ch = "r";
      7'd20: ch = "t";
      7'd21: ch = "z";
      7'd22: ch = "u";
      7'd23: ch = "i";
      7'd24: ch = "o";
      7'd25: ch = "p";
      7'd26: ch = 8'd129;
      7'd27: ch = "+";
      7'd28: ch = 8'd10;
      7'd30: ch = "a";
      7'd31: ch = "s";
      7'd32: ch = "d";
      7'd33: ch = "f";
      7'd34: ch = "g";
      7'd35: ch = "h";
      7'd36: ch = "j";
      7'd37: ch = "k";
      7'd38: ch = "l";
      7'd39: ch = 8'd148;
      7'd40: ch = 8'd132;
      7'd41: ch = "^";
      7'd43: ch = "#";
      7'd44: ch = "y";
      7'd45: ch = "x";
      7'd46: ch = "c";
      7'd47: ch = "v";
      7'd48: ch = "b";
      7'd49: ch = "n";
      7'd50: ch = "m";
      7'd51: ch = ",";
      7'd52: ch = ".";
      7'd53: ch = "-";
      7'd55: ch = "*";
      7'd57: ch = " ";
      7'd74: ch = "-";
      7'd78: ch = "+";
      7'd86: ch = "<";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // shifted layout
  function automatic logic [BYTE_W-1:0] upper_char(input logic [CODE_W-1:0] c);
    logic [BYTE_W-1:0] ch;
    ch = 8'd0;
    case (c)
      7'd2:  ch = "!";
      7'd3:  ch = "\"";
      7'd4:  ch = 8'd21;
      7'd5:  ch = "$";
      7'd6:  ch = "%";
      7'd7:  ch = "&";
      7'd8:  ch = "/";
      7'd9:  ch = "(";
      7'd10: ch = ")";
      7'd11: ch = "=";
      7'd12: ch = "?";
      7'd13: ch = 8'd96;
      7'd16: ch = "Q";
      7'd17: ch = "W";
      7'd18: ch = "E";
      7'd19: ch = "R";
      7'd20: ch = "T";
      7'd21: ch = "Z";
      7'd22: ch = "U";
      7'd23: ch = "I";
      7'd24: ch = "O";
      7'd25: ch = "P";
      7'd26: ch = 8'd154;
      7'd27: ch = "*";
      7'd30: ch = "A";
      7'd31: ch = "S";
      7'd32: ch = "D";
      7'd33: ch = "F";
      7'd34: ch = "G";
      7'd35: ch = "H";
      7'd36: ch = "J";
      7'd37: ch = "K";
      7'd38: ch = "L";
      7'd39: ch = 8'd153;
      7'd40: ch = 8'd142;
      7'd41: ch = 8'd248;
      7'd43: ch = 8'd39;
      7'd44: ch = "Y";
      7'd45: ch = "X";
      7'd46: ch = "C";
      7'd47: ch = "V";
      7'd48: ch = "B";
      7'd49: ch = "N";
      7'd50: ch = "M";
      7'd51: ch = ";";
      7'd52: ch = ":";
      7'd53: ch = "_";
      7'd57: ch = " ";
      7'd86: ch = ">";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // alt-right layout
  function automatic logic [BYTE_W-1:0] altgr_char(input logic [CODE_W-1:0] c);
    logic [BYTE_W-1:0] ch;
    ch = 8'd0;
    case (c)
      7'd3:  ch = 8'd253;
      7'd8:  ch = "{";
      7'd9:  ch = "[";
      7'd10: ch = "]";
      7'd11: ch = "}";
      7'd12: ch = "\\";
      7'd16: ch = "@";
      7'd27: ch = "~";
      7'd50: ch = 8'd230;
      7'd86: ch = "|";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // numpad under num lock: character
  function automatic logic [BYTE_W-1:0] pad_char(input logic [CODE_W-1:0] c);
    logic [BYTE_W-1:0] ch;
    ch = 8'd0;
    case (c)
      7'd71: ch = "7";
      7'd72: ch = "8";
      7'd73: ch = "9";
      7'd74: ch = "-";
      7'd75: ch = "4";
      7'd76: ch = "5";
      7'd77: ch = "6";
      7'd78: ch = "+";
      7'd79: ch = "1";
      7'd80: ch = "2";
      7'd81: ch = "3";
      7'd82: ch = "0";
      7'd83: ch = ",";
      default: ch = 8'd0;
    endcase
    return ch;
  endfunction

  // numpad under num lock: key code
  function automatic logic [CODE_W-1:0] pad_code(input logic [CODE_W-1:0] c);
    logic [CODE_W-1:0] kc;
    kc = c;
    case (c)
      7'd71: kc = 7'd8;
      7'd72: kc = 7'd9;
      7'd73: kc = 7'd10;
      7'd74: kc = 7'd53;
      7'd75: kc = 7'd5;
      7'd76: kc = 7'd6;
      7'd77: kc = 7'd7;
      7'd78: kc = 7'd27;
      7'd79: kc = 7'd2;
      7'd80: kc = 7'd3;
      7'd81: kc = 7'd4;
      7'd82: kc = 7'd11;
      7'd83: kc = 7'd51;
      default: kc = c;
    endcase
    return kc;
  endfunction

  // letter keys, affected by caps lock
  function automatic logic is_letter(input logic [CODE_W-1:0] c);
    return ((c >= 7'd16) && (c <= 7'd26)) || ((c >= 7'd30) && (c <= 7'd40)) ||
           ((c >= 7'd44) && (c <= 7'd50));
  endfunction

endpackage

// ----- rtl/scd_byte_if.sv -----
`timescale 1ns / 1ps
// scd_byte_if: valid/ready channel carrying one raw keyboard byte per word
// depends on scd_pkg

interface scd_byte_if import scd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

// ----- rtl/scd_key_if.sv -----
`timescale 1ns / 1ps
// scd_key_if: valid/ready channel carrying one decoded key result per word
// depends on scd_pkg

interface scd_key_if import scd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              key_valid;
  logic [BYTE_W-1:0] ascii_char;
  logic [CODE_W-1:0] key_code;
  logic              pressed;
  logic [MOD_W-1:0]  modifiers;
  logic [LOCK_W-1:0] locks;
  logic              led_update;
  logic              reboot_request;
  logic [HELD_W-1:0] keys_held;

  modport source (
    output valid, output key_valid, output ascii_char, output key_code, output pressed,
    output modifiers, output locks, output led_update, output reboot_request,
    output keys_held, input ready
  );
  modport sink (
    input valid, input key_valid, input ascii_char, input key_code, input pressed,
    input modifiers, input locks, input led_update, input reboot_request,
    input keys_held, output ready
  );
endinterface

// ----- rtl/scd_ram.sv -----
`timescale 1ns / 1ps
// scd_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module scd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/scd_held.sv -----
`timescale 1ns / 1ps
// scd_held: held-key set kept in a RAM, scanned once per byte, then updated
// depends on scd_pkg and scd_ram

module scd_held import scd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  held_req_t req,
  output held_rsp_t rsp
);

  typedef enum logic [2:0] {
    H_IDLE   = 3'b001,
    H_SCAN   = 3'b010,
    H_COMMIT = 3'b100
  } held_state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HELD_KEYS - 1);

  held_state_t        state;
  logic               brk;
  logic [CODE_W-1:0]  code;
  logic [IDX_W-1:0]   rd_addr;
  logic               issued_all;
  logic               rd_pend;
  logic [IDX_W-1:0]   chk_idx;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic [HELD_KEYS-1:0] slot_used;
  logic [COUNT_W-1:0] count;

  logic               ram_we;
  logic [CODE_W-1:0]  ram_rdata;
  logic               hit;
  logic               empty_slot;
  logic               do_add;
  logic               do_remove;

  scd_ram #(
    .WIDTH (CODE_W),
    .DEPTH (HELD_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (code),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // compare the word returned for the slot under check
  assign hit        = slot_used[chk_idx] && (ram_rdata == code);
  assign empty_slot = !slot_used[chk_idx];

  // set update decided after the scan; code zero is never recorded
  assign do_remove = (state == H_COMMIT) && brk && (code != KEY_NONE) && found;
  assign do_add    = (state == H_COMMIT) && !brk && (code != KEY_NONE) && !found && free_ok;
  assign ram_we    = do_add;

  assign rsp.done  = (state == H_COMMIT);
  assign rsp.count = count;

  // scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= H_IDLE;
      rd_addr    <= '0;
      issued_all <= 1'b0;
      rd_pend    <= 1'b0;
      found      <= 1'b0;
      free_ok    <= 1'b0;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (req.start) begin
            state      <= H_SCAN;
            rd_addr    <= '0;
            issued_all <= 1'b0;
            rd_pend    <= 1'b0;
            found      <= 1'b0;
            free_ok    <= 1'b0;
          end
        end
        H_SCAN: begin
          // issue one read per cycle
          if (!issued_all) begin
            rd_pend <= 1'b1;
            if (rd_addr == LAST_IDX) begin
              issued_all <= 1'b1;
            end else begin
              rd_addr <= rd_addr + IDX_W'(1);
            end
          end else begin
            rd_pend <= 1'b0;
          end
          // first matching slot and first free slot
          if (rd_pend) begin
            if (hit && !found) begin
              found <= 1'b1;
            end
            if (empty_slot && !free_ok) begin
              free_ok <= 1'b1;
            end
            if (chk_idx == LAST_IDX) begin
              state <= H_COMMIT;
            end
          end
        end
        H_COMMIT: begin
          state <= H_IDLE;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  // scan payload: latched code and slot indexes
  always_ff @(posedge clk) begin
    if (state == H_IDLE && req.start) begin
      brk  <= req.brk;
      code <= req.code;
    end
    if (state == H_SCAN && !issued_all) begin
      chk_idx <= rd_addr;
    end
    if (state == H_SCAN && rd_pend) begin
      if (hit && !found) begin
        found_idx <= chk_idx;
      end
      if (empty_slot && !free_ok) begin
        free_idx <= chk_idx;
      end
    end
  end

  // occupancy bits and count
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_used <= '0;
      count     <= '0;
    end else if (do_add) begin
      slot_used[free_idx] <= 1'b1;
      count               <= count + COUNT_W'(1);
    end else if (do_remove) begin
      slot_used[found_idx] <= 1'b0;
      count                <= count - COUNT_W'(1);
    end
  end

endmodule

// ----- rtl/scd_decode.sv -----
`timescale 1ns / 1ps
// scd_decode: prefix, modifier and lock update plus character translation for one byte
// depends on scd_pkg

module scd_decode import scd_pkg::*; (
  input  dec_in_t  din,
  output dec_out_t dout
);

  logic              brk;
  logic [CODE_W-1:0] c;
  logic              right;
  logic [BYTE_W-1:0] ch;
  logic [CODE_W-1:0] kc;

  assign brk   = din.scan_byte[BYTE_W-1];
  assign c     = din.scan_byte[CODE_W-1:0];
  assign right = (din.prefix == PFX_E0);

  // character table selection
  always_comb begin
    kc = c;
    if ((c == KEY_SLASH) && right) begin
      ch = "/";
      kc = KEY_DIV;
    end else if (din.locks[L_NUM] && (din.prefix == PFX_NONE) &&
                 (c >= KEY_PAD_LO) && (c <= KEY_DEL)) begin
      ch = pad_char(c);
      kc = pad_code(c);
    end else if (din.mods[M_ALT_R]) begin
      ch = altgr_char(c);
    end else if (din.mods[M_SHIFT]) begin
      ch = upper_char(c);
    end else if (din.locks[L_CAPS] && is_letter(c)) begin
      ch = upper_char(c);
    end else begin
      ch = plain_char(c);
    end
  end

  // state update and result
  always_comb begin
    dout.prefix_next    = din.prefix;
    dout.mods_next      = din.mods;
    dout.locks_next     = din.locks;
    dout.key_valid      = 1'b0;
    dout.ascii_char     = 8'd0;
    dout.key_code       = KEY_NONE;
    dout.led_update     = 1'b0;
    dout.reboot_request = 1'b0;
    if ((din.scan_byte == PFX_E0) || (din.scan_byte == PFX_E1)) begin
      dout.prefix_next = din.scan_byte;
    end else if (brk) begin
      if ((c == KEY_LSHIFT) || (c == KEY_RSHIFT)) begin
        dout.mods_next[M_SHIFT] = 1'b0;
        dout.prefix_next        = PFX_NONE;
      end else if (c == KEY_ALT) begin
        if (right) begin
          dout.mods_next[M_ALT_R] = 1'b0;
        end else begin
          dout.mods_next[M_ALT_L] = 1'b0;
        end
        dout.prefix_next = PFX_NONE;
      end else if (c == KEY_CTRL) begin
        if (right) begin
          dout.mods_next[M_CTRL_R] = 1'b0;
        end else begin
          dout.mods_next[M_CTRL_L] = 1'b0;
        end
        dout.prefix_next = PFX_NONE;
      end
    end else begin
      dout.prefix_next = PFX_NONE;
      if ((c == KEY_LSHIFT) || (c == KEY_RSHIFT)) begin
        dout.mods_next[M_SHIFT] = 1'b1;
      end else if (c == KEY_ALT) begin
        if (right) begin
          dout.mods_next[M_ALT_R] = 1'b1;
        end else begin
          dout.mods_next[M_ALT_L] = 1'b1;
        end
      end else if (c == KEY_CTRL) begin
        if (right) begin
          dout.mods_next[M_CTRL_R] = 1'b1;
        end else begin
          dout.mods_next[M_CTRL_L] = 1'b1;
        end
      end else if (c == KEY_CAPS) begin
        dout.locks_next[L_CAPS] = !din.locks[L_CAPS];
        dout.led_update         = 1'b1;
      end else if (c == KEY_SCROLL) begin
        dout.locks_next[L_SCROLL] = !din.locks[L_SCROLL];
        dout.led_update           = 1'b1;
      end else if ((c == KEY_NUM) && !din.mods[M_CTRL_L]) begin
        dout.locks_next[L_NUM] = !din.locks[L_NUM];
        dout.led_update        = 1'b1;
      end else begin
        // ordinary key: character result, ctrl+alt+delete check
        dout.key_valid      = 1'b1;
        dout.ascii_char     = ch;
        dout.key_code       = kc;
        dout.reboot_request = (din.mods[M_CTRL_L] || din.mods[M_CTRL_R]) &&
                              (din.mods[M_ALT_L] || din.mods[M_ALT_R]) && (kc == KEY_DEL);
      end
    end
  end

endmodule

// ----- rtl/scan_code_set1_key_decoder.sv -----
`timescale 1ns / 1ps
// scan_code_set1_key_decoder: one result word per keyboard byte, one byte in flight at a time
// result path: the held-key RAM is scanned, one read per cycle, then the set is updated and
// the decoded word is registered for output
// a new byte is taken while the result waits in the output register
// reset: prefix, modifiers, locks, held set and count all cleared, no result pending
// depends on scd_pkg, scd_byte_if, scd_key_if, scd_held, scd_decode

module scan_code_set1_key_decoder import scd_pkg::*; (
  input logic      clk,
  input logic      rst,
  scd_byte_if.sink scan_in,
  scd_key_if.source key_out
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_WAIT = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t        state;
  logic [BYTE_W-1:0] cur_byte;
  logic [BYTE_W-1:0] prefix;
  logic [MOD_W-1:0]  mods;
  logic [LOCK_W-1:0] locks;

  logic              out_valid;
  logic              out_key_valid;
  logic [BYTE_W-1:0] out_ascii;
  logic [CODE_W-1:0] out_code;
  logic              out_pressed;
  logic [MOD_W-1:0]  out_mods;
  logic [LOCK_W-1:0] out_locks;
  logic              out_led;
  logic              out_reboot;
  logic [HELD_W-1:0] out_held;

  logic      accept;
  logic      load;
  held_req_t held_req;
  held_rsp_t held_rsp;
  dec_in_t   dec_in;
  dec_out_t  dec_out;

  assign scan_in.ready = (state == T_IDLE);
  assign accept        = scan_in.valid && scan_in.ready;
  assign load          = (state == T_OUT) && (!out_valid || key_out.ready);

  // held-key set sequencer
  assign held_req.start = accept;
  assign held_req.brk   = scan_in.scan_byte[BYTE_W-1];
  assign held_req.code  = scan_in.scan_byte[CODE_W-1:0];

  scd_held u_held (
    .clk (clk),
    .rst (rst),
    .req (held_req),
    .rsp (held_rsp)
  );

  // byte decoding against current state
  assign dec_in.scan_byte = cur_byte;
  assign dec_in.prefix    = prefix;
  assign dec_in.mods      = mods;
  assign dec_in.locks     = locks;

  scd_decode u_decode (
    .din  (dec_in),
    .dout (dec_out)
  );

  // control sequence and decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      prefix <= PFX_NONE;
      mods   <= '0;
      locks  <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            state <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (held_rsp.done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (load) begin
            state  <= T_IDLE;
            prefix <= dec_out.prefix_next;
            mods   <= dec_out.mods_next;
            locks  <= dec_out.locks_next;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // accepted byte
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= scan_in.scan_byte;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (key_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key_valid <= dec_out.key_valid;
      out_ascii     <= dec_out.ascii_char;
      out_code      <= dec_out.key_code;
      out_pressed   <= !cur_byte[BYTE_W-1];
      out_mods      <= dec_out.mods_next;
      out_locks     <= dec_out.locks_next;
      out_led       <= dec_out.led_update;
      out_reboot    <= dec_out.reboot_request;
      out_held      <= HELD_W'(held_rsp.count);
    end
  end

  assign key_out.valid          = out_valid;
  assign key_out.key_valid      = out_key_valid;
  assign key_out.ascii_char     = out_ascii;
  assign key_out.key_code       = out_code;
  assign key_out.pressed        = out_pressed;
  assign key_out.modifiers      = out_mods;
  assign key_out.locks          = out_locks;
  assign key_out.led_update     = out_led;
  assign key_out.reboot_request = out_reboot;
  assign key_out.keys_held      = out_held;

endmodule
